/* hw/rtl/qrs_pkg.sv */
// Shared widths, codes, cell state types and a helper function of the quadratic root solver.
package qrs_pkg;

	localparam int COEF_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int TOL_WIDTH  = 16;
	localparam int PROD_W     = 2 * COEF_WIDTH;
	localparam int DISC_W     = 2 * COEF_WIDTH + 1;
	localparam int SQ_W       = COEF_WIDTH + 1;
	localparam int RAD_W      = 2 * SQ_W;
	localparam int SREM_W     = SQ_W + 2;
	localparam int NUM_W      = SQ_W + 1;
	localparam int DIVN_W     = NUM_W + FRAC_BITS;
	localparam int DEN_W      = COEF_WIDTH + 1;

	localparam logic [1:0] ADDR_ZERO_TOL = 2'd0;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_TWO  = 2'd2,
		KIND_ALL  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_ZERO_C,
		MODE_POS,
		MODE_DOUBLE,
		MODE_LINEAR
	} mode_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [SQ_W-1:0]   root;
	} sqrt_t;

	typedef struct packed {
		logic [DIVN_W-1:0] num;
		logic [DEN_W-1:0]  rem;
		logic [DIVN_W-1:0] quo;
		logic [DEN_W-1:0]  den;
	} div_t;

	typedef struct packed {
		logic                  neg;
		logic [NUM_W-1:0]      mag;
	} sm_t;

	function automatic sm_t sm_add(input logic s1, input logic [NUM_W-1:0] m1,
			input logic s2, input logic [NUM_W-1:0] m2);
		sm_t r;
		if (s1 == s2) begin
			r.neg = s1;
			r.mag = m1 + m2;
		end else if (m1 >= m2) begin
			r.neg = s1;
			r.mag = m1 - m2;
		end else begin
			r.neg = s2;
			r.mag = m2 - m1;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/quadratic_root_solver.sv */
// Top level of the quadratic root solver: front stages, cell chains and output register.
// The solver takes one equation per cycle while the output is not stalled and returns one
// result per equation in order. Each equation passes through stage 1, stage 2, the square
// root chain of one cell per root bit, stage 3, the two parallel divider chains of one cell
// per quotient bit and the output register. A stalled output holds the whole pipeline except
// an empty first stage, which still takes one more equation.
module quadratic_root_solver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_a,
	input  logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_b,
	input  logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_c,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         root_kind,
	output logic signed [qrs_pkg::COEF_WIDTH-1:0] root_first,
	output logic signed [qrs_pkg::COEF_WIDTH-1:0] root_second,
	output logic                               overflowed,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [1:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import qrs_pkg::*;

	localparam int W = COEF_WIDTH;

	typedef struct packed {
		logic           valid;
		mode_t          mode;
		kind_t          kind;
		logic           sa;
		logic           sb;
		logic           sc;
		logic [W-1:0]   ma;
		logic [W-1:0]   mb;
		logic [W-1:0]   mc;
	} side_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
		logic  act1;
		logic  act2;
		logic  neg1;
		logic  neg2;
	} dside_t;

	logic [TOL_WIDTH-1:0] tol_q;
	logic                 en;
	logic                 ld1;
	logic                 v_s1;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = 32'(tol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (psel && penable && pwrite && paddr == ADDR_ZERO_TOL) begin
			tol_q <= pwdata[TOL_WIDTH-1:0];
		end
	end

	assign en       = !out_valid || out_ready;
	assign ld1      = en || !v_s1;
	assign in_ready = ld1;

	// Stage 1: magnitudes, zero tests and products.
	logic           sa_s1, sb_s1, sc_s1;
	logic           za_s1, zb_s1, zc_s1;
	logic [W-1:0]   ma_s1, mb_s1, mc_s1;
	logic [PROD_W-1:0] b2_s1, ac_s1;
	logic [W-1:0]   ma_in, mb_in, mc_in;

	assign ma_in = coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
	assign mb_in = coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
	assign mc_in = coef_c[W-1] ? W'(-coef_c) : W'(coef_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			sa_s1 <= coef_a[W-1];
			sb_s1 <= coef_b[W-1];
			sc_s1 <= coef_c[W-1];
			ma_s1 <= ma_in;
			mb_s1 <= mb_in;
			mc_s1 <= mc_in;
			za_s1 <= ma_in <= W'(tol_q);
			zb_s1 <= mb_in <= W'(tol_q);
			zc_s1 <= mc_in <= W'(tol_q);
			b2_s1 <= PROD_W'(mb_in) * PROD_W'(mb_in);
			ac_s1 <= PROD_W'(ma_in) * PROD_W'(mc_in);
		end
	end

	// Stage 2: discriminant and classification.
	logic [PROD_W+1:0] ac4_full;
	logic [DISC_W-1:0] b2x, ac4, tol2, dmag;
	logic              dneg;
	side_t             side_n;
	side_t             side_s2;
	logic [DISC_W-1:0] dmag_s2;

	always_comb begin
		ac4_full = {ac_s1, 2'b00};
		ac4      = ac4_full[DISC_W-1:0];
		b2x      = DISC_W'(b2_s1);
		tol2     = DISC_W'({tol_q, {FRAC_BITS{1'b0}}});
		if (sa_s1 != sc_s1) begin
			dmag = b2x + ac4;
			dneg = 1'b0;
		end else if (b2x >= ac4) begin
			dmag = b2x - ac4;
			dneg = 1'b0;
		end else begin
			dmag = ac4 - b2x;
			dneg = 1'b1;
		end
		side_n.valid = v_s1;
		side_n.sa    = sa_s1;
		side_n.sb    = sb_s1;
		side_n.sc    = sc_s1;
		side_n.ma    = ma_s1;
		side_n.mb    = mb_s1;
		side_n.mc    = mc_s1;
		if (!za_s1) begin
			if (zc_s1) begin
				side_n.mode = MODE_ZERO_C;
				side_n.kind = KIND_TWO;
			end else if (!dneg && dmag > tol2) begin
				side_n.mode = MODE_POS;
				side_n.kind = KIND_TWO;
			end else if (dmag <= tol2) begin
				side_n.mode = MODE_DOUBLE;
				side_n.kind = KIND_ONE;
			end else begin
				side_n.mode = MODE_NONE;
				side_n.kind = KIND_NONE;
			end
		end else if (!zb_s1) begin
			side_n.mode = MODE_LINEAR;
			side_n.kind = KIND_ONE;
		end else begin
			side_n.mode = MODE_NONE;
			side_n.kind = zc_s1 ? KIND_ALL : KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			dmag_s2 <= '0;
		end else if (en) begin
			side_s2 <= side_n;
			dmag_s2 <= dmag;
		end
	end

	// Square root chain.
	sqrt_t sq_in;
	sqrt_t sq_c [SQ_W];
	side_t sd_q [SQ_W];

	assign sq_in.rad  = RAD_W'(dmag_s2);
	assign sq_in.rem  = '0;
	assign sq_in.root = '0;

	for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
		if (i == 0) begin : g_first
			qrs_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq_in), .q(sq_c[i]));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sd_q[i] <= '0;
				end else if (en) begin
					sd_q[i] <= side_s2;
				end
			end
		end else begin : g_next
			qrs_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq_c[i-1]), .q(sq_c[i]));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sd_q[i] <= '0;
				end else if (en) begin
					sd_q[i] <= sd_q[i-1];
				end
			end
		end
	end

	// Stage 3: numerators and divisors.
	side_t            st;
	logic [NUM_W-1:0] s_root, mb_n, mc_n;
	sm_t              n1, n2;
	logic [DEN_W-1:0] den;
	dside_t           ds_n;
	dside_t           ds_s3;
	div_t             dv1_s3, dv2_s3;

	always_comb begin
		st     = sd_q[SQ_W-1];
		s_root = NUM_W'(sq_c[SQ_W-1].root);
		mb_n   = NUM_W'(st.mb);
		mc_n   = NUM_W'(st.mc);
		n1.neg = !st.sb;
		n1.mag = mb_n;
		n2.neg = 1'b0;
		n2.mag = '0;
		den    = {st.ma, 1'b0};
		ds_n.valid = st.valid;
		ds_n.kind  = st.kind;
		ds_n.act1  = 1'b0;
		ds_n.act2  = 1'b0;
		case (st.mode)
			MODE_ZERO_C: begin
				den       = DEN_W'(st.ma);
				ds_n.act1 = 1'b1;
			end
			MODE_POS: begin
				n1        = sm_add(!st.sb, mb_n, 1'b0, s_root);
				n2        = sm_add(!st.sb, mb_n, 1'b1, s_root);
				ds_n.act1 = 1'b1;
				ds_n.act2 = 1'b1;
			end
			MODE_DOUBLE: begin
				ds_n.act1 = 1'b1;
			end
			MODE_LINEAR: begin
				n1.neg    = !st.sc;
				n1.mag    = mc_n;
				den       = DEN_W'(st.mb);
				ds_n.act1 = 1'b1;
			end
			default: begin
				ds_n.act1 = 1'b0;
			end
		endcase
		ds_n.neg1 = n1.neg != ((st.mode == MODE_LINEAR) ? st.sb : st.sa);
		ds_n.neg2 = n2.neg != st.sa;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_s3 <= '0;
		end else if (en) begin
			ds_s3 <= ds_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv1_s3.num  <= {n1.mag, {FRAC_BITS{1'b0}}};
			dv1_s3.rem  <= '0;
			dv1_s3.quo  <= '0;
			dv1_s3.den  <= den;
			dv2_s3.num  <= {n2.mag, {FRAC_BITS{1'b0}}};
			dv2_s3.rem  <= '0;
			dv2_s3.quo  <= '0;
			dv2_s3.den  <= den;
		end
	end

	// Divider chains, one for each root.
	div_t   d1_c [DIVN_W];
	div_t   d2_c [DIVN_W];
	dside_t dd_q [DIVN_W];

	for (genvar j = 0; j < DIVN_W; j++) begin : g_div
		if (j == 0) begin : g_first
			qrs_div_cell u_cell1 (.clk(clk), .en(en), .d(dv1_s3), .q(d1_c[j]));
			qrs_div_cell u_cell2 (.clk(clk), .en(en), .d(dv2_s3), .q(d2_c[j]));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dd_q[j] <= '0;
				end else if (en) begin
					dd_q[j] <= ds_s3;
				end
			end
		end else begin : g_next
			qrs_div_cell u_cell1 (.clk(clk), .en(en), .d(d1_c[j-1]), .q(d1_c[j]));
			qrs_div_cell u_cell2 (.clk(clk), .en(en), .d(d2_c[j-1]), .q(d2_c[j]));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dd_q[j] <= '0;
				end else if (en) begin
					dd_q[j] <= dd_q[j-1];
				end
			end
		end
	end

	// Saturation, sign and output register.
	dside_t            df;
	logic [DIVN_W-1:0] lim1, lim2, q1, q2;
	logic [W-1:0]      mag1, mag2, r1, r2;
	logic              ov1, ov2;

	always_comb begin
		df   = dd_q[DIVN_W-1];
		q1   = d1_c[DIVN_W-1].quo;
		q2   = d2_c[DIVN_W-1].quo;
		lim1 = (DIVN_W'(1) << (W - 1)) - DIVN_W'(!df.neg1);
		lim2 = (DIVN_W'(1) << (W - 1)) - DIVN_W'(!df.neg2);
		ov1  = q1 > lim1;
		ov2  = q2 > lim2;
		mag1 = ov1 ? lim1[W-1:0] : q1[W-1:0];
		mag2 = ov2 ? lim2[W-1:0] : q2[W-1:0];
		r1   = df.neg1 ? W'(-mag1) : mag1;
		r2   = df.neg2 ? W'(-mag2) : mag2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= df.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_kind   <= df.kind;
			root_first  <= df.act1 ? r1 : '0;
			root_second <= df.act2 ? r2 : '0;
			overflowed  <= (df.act1 && ov1) || (df.act2 && ov2);
		end
	end

endmodule

/* hw/rtl/qrs_sqrt_cell.sv */
// One cell of the square root chain: retires one root bit per cycle while enabled.
module qrs_sqrt_cell (
	input  logic          clk,
	input  logic          en,
	input  qrs_pkg::sqrt_t d,
	output qrs_pkg::sqrt_t q
);
	import qrs_pkg::*;

	logic [SREM_W+1:0] remn;
	logic [SREM_W+1:0] trial;
	sqrt_t nxt;

	always_comb begin
		remn  = {d.rem, d.rad[RAD_W-1 -: 2]};
		trial = (SREM_W+2)'({d.root, 2'b01});
		nxt.rad = {d.rad[RAD_W-3:0], 2'b00};
		if (remn >= trial) begin
			nxt.rem  = SREM_W'(remn - trial);
			nxt.root = {d.root[SQ_W-2:0], 1'b1};
		end else begin
			nxt.rem  = SREM_W'(remn);
			nxt.root = {d.root[SQ_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

/* hw/rtl/qrs_div_cell.sv */
// One cell of the restoring divider chain: retires one quotient bit per cycle while enabled.
module qrs_div_cell (
	input  logic         clk,
	input  logic         en,
	input  qrs_pkg::div_t d,
	output qrs_pkg::div_t q
);
	import qrs_pkg::*;

	logic [DEN_W:0] remn;
	div_t nxt;

	always_comb begin
		remn    = {d.rem, d.num[DIVN_W-1]};
		nxt.num = {d.num[DIVN_W-2:0], 1'b0};
		nxt.den = d.den;
		if (remn >= {1'b0, d.den}) begin
			nxt.rem = DEN_W'(remn - {1'b0, d.den});
			nxt.quo = {d.quo[DIVN_W-2:0], 1'b1};
		end else begin
			nxt.rem = DEN_W'(remn);
			nxt.quo = {d.quo[DIVN_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

/* hw/rtl/qrs_checker.sv */
// Port-level assertions for the quadratic root solver and their bind.
module qrs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [1:0]                         root_kind,
	input logic [qrs_pkg::COEF_WIDTH-1:0]     root_first,
	input logic [qrs_pkg::COEF_WIDTH-1:0]     root_second,
	input logic                               overflowed,
	input logic                               pready
);
	import qrs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root_first) && $stable(root_kind))
		else $error("Stalled result changed before its transfer.");

	a_no_roots: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_kind == KIND_NONE || root_kind == KIND_ALL) |->
		root_first == '0 && root_second == '0 && !overflowed)
		else $error("A result without roots carries root values.");

	a_one_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_ONE |-> root_second == '0)
		else $error("A single-root result carries a second root.");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("Configuration port inserted a wait state.");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.root_kind(root_kind),
	.root_first(root_first),
	.root_second(root_second),
	.overflowed(overflowed),
	.pready(pready)
);
